[sv/i2cm_pkg.sv]
// i2cm_pkg: shared types, codes and reset values of the I2C register access master.
// Depends on nothing; every other file of the block imports it.

package i2cm_pkg;

	// Bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_NEXT,
		PH_ST_A,
		PH_ST_B,
		PH_ST_C,
		PH_WB_A,
		PH_WB_B,
		PH_WB_C,
		PH_ACK_A,
		PH_ACK_B,
		PH_ACK_C,
		PH_RB_A,
		PH_RB_B,
		PH_NK_A,
		PH_NK_B,
		PH_NK_C,
		PH_SP_A,
		PH_SP_B,
		PH_SP_C,
		PH_FS_A,
		PH_FS_B,
		PH_FS_C,
		PH_FIN_OK,
		PH_FIN_FAIL,
		PH_RETRY
	} phase_t;

	// Request codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_PROBE = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Register map (index = byte address / 4)
	localparam logic [2:0] REG_DEV_ADDR    = 3'd0;
	localparam logic [2:0] REG_HALF_PERIOD = 3'd1;
	localparam logic [2:0] REG_ACK_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_MAX_ATTEMPT = 3'd3;
	localparam logic [2:0] REG_RETRY_GAP   = 3'd4;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	// Register reset values
	localparam logic [6:0]  RST_DEV_ADDR    = 7'd16;
	localparam logic [15:0] RST_HALF_PERIOD = 16'd240;
	localparam logic [7:0]  RST_ACK_TIMEOUT = 8'd250;
	localparam logic [2:0]  RST_MAX_ATTEMPT = 3'd3;
	localparam logic [15:0] RST_RETRY_GAP   = 16'd1000;

	typedef struct packed {
		logic [6:0]  dev_addr;
		logic [15:0] half_period;
		logic [7:0]  ack_timeout;
		logic [2:0]  max_attempt;
		logic [15:0] retry_gap;
	} cfg_t;

	// One tick word after classification
	typedef struct packed {
		logic       start;
		logic [1:0] cmd;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] read_data;
	} result_t;

endpackage

[sv/i2cm_cfg.sv]
// i2cm_cfg: APB-style configuration registers of the I2C register access master.
// Depends on i2cm_pkg for the register map, reset values and cfg_t.

module i2cm_cfg import i2cm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr    <= RST_DEV_ADDR;
			cfg_q.half_period <= RST_HALF_PERIOD;
			cfg_q.ack_timeout <= RST_ACK_TIMEOUT;
			cfg_q.max_attempt <= RST_MAX_ATTEMPT;
			cfg_q.retry_gap   <= RST_RETRY_GAP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEV_ADDR:    cfg_q.dev_addr    <= pwdata[6:0];
				REG_HALF_PERIOD: cfg_q.half_period <= pwdata[15:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= pwdata[7:0];
				REG_MAX_ATTEMPT: cfg_q.max_attempt <= pwdata[2:0];
				REG_RETRY_GAP:   cfg_q.retry_gap   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		case (reg_idx)
			REG_DEV_ADDR:    prdata = {25'd0, cfg_q.dev_addr};
			REG_HALF_PERIOD: prdata = {16'd0, cfg_q.half_period};
			REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout};
			REG_MAX_ATTEMPT: prdata = {29'd0, cfg_q.max_attempt};
			REG_RETRY_GAP:   prdata = {16'd0, cfg_q.retry_gap};
			default:         prdata = '0;
		endcase
	end

endmodule

[sv/i2cm_front.sv]
// i2cm_front: accepts tick words, classifies the request and holds them in a
// two-entry queue for the bus sequencer. Depends on i2cm_pkg for item_t and codes.

module i2cm_front import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       request_valid,
	input  logic [1:0] cmd,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	output logic       item_valid,
	output item_t      item,
	input  logic       item_take
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_acc;
	logic       take_acc;
	item_t      new_item;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign push_acc   = push & ~full;
	assign take_acc   = item_take & item_valid;
	assign item       = mem_q[rd_ptr_q];

	// Classify: a request counts only with a defined command code
	always_comb begin
		new_item.start      = request_valid & (cmd != CMD_NONE);
		new_item.cmd        = cmd;
		new_item.reg_addr   = reg_addr;
		new_item.write_data = write_data;
		new_item.sda_in     = sda_in;
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push_acc) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_acc) wr_ptr_q <= ~wr_ptr_q;
			if (take_acc) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push_acc} - {1'b0, take_acc};
		end
	end

endmodule

[sv/i2cm_back.sv]
// i2cm_back: bus sequencer that advances one tick per word, plus the two-entry
// result queue. Depends on i2cm_pkg for phase_t, cfg_t, item_t, result_t and codes.

module i2cm_back import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	output logic    item_take,
	output logic    empty,
	input  logic    pop,
	output result_t res
);

	// Sequencer state
	phase_t      phase_q, phase_d;
	logic [2:0]  byte_step_q, byte_step_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [15:0] delay_q, delay_d;
	logic [7:0]  ack_cnt_q, ack_cnt_d;
	logic [2:0]  attempt_q, attempt_d;
	logic [7:0]  shift_q, shift_d;
	logic [1:0]  cmd_q, cmd_d;
	logic [7:0]  reg_q, reg_d;
	logic [7:0]  data_q, data_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;

	// Result queue
	result_t     oq_q [2];
	logic        owr_q;
	logic        ord_q;
	logic [1:0]  ocnt_q;
	logic        pop_acc;
	result_t     res_d;

	logic [15:0] h_wait;
	logic [2:0]  att_inc;
	logic [2:0]  att_lim;
	logic        fail_end;
	logic        run;

	assign empty     = (ocnt_q == 2'd0);
	assign pop_acc   = pop & ~empty;
	assign item_take = item_valid & ((ocnt_q != 2'd2) | pop_acc);
	assign res       = oq_q[ord_q];

	// Shared terms
	assign h_wait   = (cfg.half_period == 16'd0) ? 16'd0 : cfg.half_period - 16'd1;
	assign att_inc  = attempt_q + 3'd1;
	assign att_lim  = (cfg.max_attempt == 3'd0) ? 3'd1 : cfg.max_attempt;
	assign fail_end = (cmd_q == CMD_PROBE) || (att_inc >= att_lim);
	assign run      = (delay_q == 16'd0) && (phase_q != PH_IDLE);

	// Next state: settle, dispatch, then the phase that starts a delay
	always_comb begin : next_state
		logic       go;
		phase_t     ph;
		logic [2:0] step;
		logic [7:0] aw;

		phase_d     = phase_q;
		byte_step_d = byte_step_q;
		bit_cnt_d   = bit_cnt_q;
		delay_d     = delay_q;
		ack_cnt_d   = ack_cnt_q;
		attempt_d   = attempt_q;
		shift_d     = shift_q;
		cmd_d       = cmd_q;
		reg_d       = reg_q;
		data_d      = data_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		go          = 1'b0;
		ph          = phase_q;
		step        = byte_step_q;
		aw          = {cfg.dev_addr, 1'b0};

		// delay countdown, or request latch when idle
		if (delay_q != 16'd0) begin
			delay_d = delay_q - 16'd1;
		end else if (phase_q == PH_IDLE) begin
			if (item.start) begin
				cmd_d       = item.cmd;
				reg_d       = item.reg_addr;
				data_d      = item.write_data;
				attempt_d   = 3'd0;
				byte_step_d = 3'd0;
				ph          = PH_NEXT;
				go          = 1'b1;
			end
		end else begin
			go = 1'b1;
		end

		// phases that resolve without a delay of their own
		if (go) begin
			case (ph)
				PH_WB_C: begin
					scl_d     = 1'b0;
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 4'd1;
					ph        = (bit_cnt_d < 4'd8) ? PH_WB_A : PH_ACK_A;
				end
				PH_ACK_C: begin
					if (!item.sda_in) begin
						scl_d   = 1'b0;
						delay_d = h_wait;
						ph      = PH_NEXT;
						go      = 1'b0;
					end else if (ack_cnt_q >= cfg.ack_timeout) begin
						ph = PH_FS_A;
					end else begin
						ack_cnt_d = ack_cnt_q + 8'd1;
						go        = 1'b0;
					end
				end
				PH_FIN_OK: begin
					ph = PH_IDLE;
					go = 1'b0;
				end
				PH_FIN_FAIL: begin
					attempt_d = att_inc;
					if (fail_end) begin
						ph = PH_IDLE;
						go = 1'b0;
					end else if (cfg.retry_gap == 16'd0) begin
						byte_step_d = 3'd0;
						ph          = PH_NEXT;
					end else begin
						delay_d = cfg.retry_gap - 16'd1;
						ph      = PH_RETRY;
						go      = 1'b0;
					end
				end
				PH_RETRY: begin
					byte_step_d = 3'd0;
					ph          = PH_NEXT;
				end
				default: ;
			endcase
		end

		// pick the next segment of the transaction
		if (go && ph == PH_NEXT) begin
			step        = byte_step_d;
			byte_step_d = step + 3'd1;
			bit_cnt_d   = 4'd0;
			ph          = PH_SP_A;
			if (step == 3'd0) begin
				ph = PH_ST_A;
			end else if (step == 3'd1) begin
				ph      = PH_WB_A;
				shift_d = aw;
			end else if (cmd_d == CMD_WRITE) begin
				if (step == 3'd2) begin
					ph      = PH_WB_A;
					shift_d = reg_d;
				end else if (step == 3'd3) begin
					ph      = PH_WB_A;
					shift_d = data_d;
				end
			end else if (cmd_d == CMD_READ) begin
				if (step == 3'd2) begin
					ph      = PH_WB_A;
					shift_d = reg_d;
				end else if (step == 3'd3) begin
					ph = PH_ST_A;
				end else if (step == 3'd4) begin
					ph      = PH_WB_A;
					shift_d = aw | 8'h01;
				end else if (step == 3'd5) begin
					ph      = PH_RB_A;
					shift_d = 8'h00;
				end
			end
		end

		// line changes that open a delay phase
		if (go) begin
			case (ph)
				PH_ST_A: begin
					sda_d = 1'b1; scl_d = 1'b1; delay_d = h_wait; ph = PH_ST_B;
				end
				PH_ST_B: begin
					sda_d = 1'b0; delay_d = h_wait; ph = PH_ST_C;
				end
				PH_ST_C: begin
					scl_d = 1'b0; delay_d = h_wait; ph = PH_NEXT;
				end
				PH_WB_A: begin
					sda_d = shift_d[7]; delay_d = h_wait; ph = PH_WB_B;
				end
				PH_WB_B: begin
					scl_d = 1'b1; delay_d = h_wait; ph = PH_WB_C;
				end
				PH_ACK_A: begin
					sda_d = 1'b1; delay_d = h_wait; ph = PH_ACK_B;
				end
				PH_ACK_B: begin
					scl_d = 1'b1; ack_cnt_d = 8'd0; delay_d = h_wait; ph = PH_ACK_C;
				end
				PH_RB_A: begin
					shift_d = {shift_d[6:0], 1'b0};
					scl_d   = 1'b1;
					delay_d = h_wait;
					ph      = PH_RB_B;
				end
				PH_RB_B: begin
					shift_d[0] = shift_d[0] | item.sda_in;
					scl_d      = 1'b0;
					bit_cnt_d  = bit_cnt_q + 4'd1;
					delay_d    = h_wait;
					ph         = (bit_cnt_d < 4'd8) ? PH_RB_A : PH_NK_A;
				end
				PH_NK_A: begin
					sda_d = 1'b1; delay_d = h_wait; ph = PH_NK_B;
				end
				PH_NK_B: begin
					scl_d = 1'b1; delay_d = h_wait; ph = PH_NK_C;
				end
				PH_NK_C: begin
					scl_d = 1'b0; delay_d = h_wait; ph = PH_NEXT;
				end
				PH_SP_A: begin
					sda_d = 1'b0; delay_d = h_wait; ph = PH_SP_B;
				end
				PH_SP_B: begin
					scl_d = 1'b1; delay_d = h_wait; ph = PH_SP_C;
				end
				PH_SP_C: begin
					sda_d = 1'b1; delay_d = h_wait; ph = PH_FIN_OK;
				end
				PH_FS_A: begin
					sda_d = 1'b0; delay_d = h_wait; ph = PH_FS_B;
				end
				PH_FS_B: begin
					scl_d = 1'b1; delay_d = h_wait; ph = PH_FS_C;
				end
				PH_FS_C: begin
					sda_d = 1'b1; delay_d = h_wait; ph = PH_FIN_FAIL;
				end
				default: ;
			endcase
		end

		phase_d = ph;
	end

	// Result word for this tick
	always_comb begin : outputs
		res_d.scl_level   = scl_d;
		res_d.sda_release = sda_d;
		res_d.busy_res    = (phase_d != PH_IDLE);
		res_d.done_res    = run && ((phase_q == PH_FIN_OK) ||
		                            (phase_q == PH_FIN_FAIL && fail_end));
		res_d.status      = run && (phase_q == PH_FIN_FAIL) && fail_end;
		res_d.read_data   = (run && phase_q == PH_FIN_OK && cmd_q == CMD_READ) ?
		                    shift_q : 8'h00;
	end

	// Sequencer registers, advanced once per word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_step_q <= 3'd0;
			bit_cnt_q   <= 4'd0;
			delay_q     <= 16'd0;
			ack_cnt_q   <= 8'd0;
			attempt_q   <= 3'd0;
			shift_q     <= 8'h00;
			cmd_q       <= 2'd0;
			reg_q       <= 8'h00;
			data_q      <= 8'h00;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else if (item_take) begin
			phase_q     <= phase_d;
			byte_step_q <= byte_step_d;
			bit_cnt_q   <= bit_cnt_d;
			delay_q     <= delay_d;
			ack_cnt_q   <= ack_cnt_d;
			attempt_q   <= attempt_d;
			shift_q     <= shift_d;
			cmd_q       <= cmd_d;
			reg_q       <= reg_d;
			data_q      <= data_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (item_take) begin
			oq_q[owr_q] <= res_d;
		end
	end

	// Result queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (item_take) owr_q <= ~owr_q;
			if (pop_acc)   ord_q <= ~ord_q;
			ocnt_q <= ocnt_q + {1'b0, item_take} - {1'b0, pop_acc};
		end
	end

endmodule

[sv/i2c_register_access_master.sv]
// i2c_register_access_master: top level of the tick-driven I2C register master.
// Depends on i2cm_pkg, i2cm_cfg, i2cm_front and i2cm_back.
//
//   channel   handshake            contents
//   -------   ------------------   ---------------------------------------------
//   config    psel/penable/pwrite  device address, half period, ack timeout,
//                                  attempts, retry gap (APB, pready tied high)
//   tick in   push / full          request_valid, cmd, reg_addr, write_data, sda_in
//   result    pop / empty          scl_level, sda_release, busy_res, done_res,
//                                  status, read_data
//
// One word a cycle unless a queue stalls: the sequencer advances one bus tick
// per word taken; the front queue and the result queue each hold two words.
// A pushed word is stored in the front queue, then its result in the result queue.
// Reset puts the registers at their defaults and leaves both lines released.
// full rises when two words wait in the front queue; the sequencer halts while
// the result queue holds two words and pop is low.

module i2c_register_access_master import i2cm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  push,
	output logic                  full,
	input  logic                  request_valid,
	input  logic [1:0]            cmd,
	input  logic [7:0]            reg_addr,
	input  logic [7:0]            write_data,
	input  logic                  sda_in,
	output logic                  empty,
	input  logic                  pop,
	output logic                  scl_level,
	output logic                  sda_release,
	output logic                  busy_res,
	output logic                  done_res,
	output logic                  status,
	output logic [7:0]            read_data
);

	cfg_t    cfg;
	item_t   item;
	logic    item_valid;
	logic    item_take;
	result_t res;

	i2cm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.request_valid (request_valid),
		.cmd           (cmd),
		.reg_addr      (reg_addr),
		.write_data    (write_data),
		.sda_in        (sda_in),
		.item_valid    (item_valid),
		.item          (item),
		.item_take     (item_take)
	);

	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign scl_level   = res.scl_level;
	assign sda_release = res.sda_release;
	assign busy_res    = res.busy_res;
	assign done_res    = res.done_res;
	assign status      = res.status;
	assign read_data   = res.read_data;

	// A finished request leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> !busy_res)
		else $error("done word still marked busy");

	// Failure status only comes with done
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> done_res)
		else $error("status set without done");

	// Read data only comes with done
	a_rdata_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (read_data != 8'h00)) |-> done_res)
		else $error("read data outside done word");

	// Bus is released whenever the sequencer is idle
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !busy_res) |-> (scl_level && sda_release))
		else $error("bus driven while idle");

endmodule
